### design/ple_pkg.sv
`default_nettype none

package ple_pkg;

	localparam int unsigned DATA_W       = 32;
	localparam int unsigned DEF_CAPACITY = 64;

	// operation codes of the input word
	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_AT    = 3'd2,
		OP_REM_FRONT = 3'd3,
		OP_REM_BACK  = 3'd4,
		OP_REM_AT    = 3'd5,
		OP_CONTAINS  = 3'd6,
		OP_READ      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// action broadcast to every cell
	typedef enum logic [2:0] {
		K_NONE = 3'd0,
		K_INS  = 3'd1,
		K_REM  = 3'd2,
		K_CMP  = 3'd3,
		K_RD   = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [DATA_W-1:0]  value;
	} cell_ctrl_t;

endpackage

`default_nettype wire

### design/ple_cell.sv
`default_nettype none

module ple_cell #(
	parameter int unsigned CNT_W = 7,
	parameter int unsigned INDEX = 0
) (
	input  wire logic                       clk,
	input  wire ple_pkg::cell_ctrl_t        ctrl,
	input  wire logic [CNT_W-1:0]           pos,
	input  wire logic [CNT_W-1:0]           cnt,
	input  wire logic [ple_pkg::DATA_W-1:0] left_data,
	input  wire logic [ple_pkg::DATA_W-1:0] right_data,
	output logic      [ple_pkg::DATA_W-1:0] data,
	output logic                            hit,
	output logic      [ple_pkg::DATA_W-1:0] rd_data
);
	import ple_pkg::*;

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

	logic [DATA_W-1:0] entry_q;
	logic              hit_q;
	logic [DATA_W-1:0] rd_q;

	// entry: take from left on insert above the gap, the new value at the gap, from right on remove
	always_ff @(posedge clk) begin
		case (ctrl.kind)
			K_INS: begin
				if (MY_IDX > pos) begin
					entry_q <= left_data;
				end else if (MY_IDX == pos) begin
					entry_q <= ctrl.value;
				end
			end
			K_REM: begin
				if (MY_IDX >= pos) begin
					entry_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		hit_q <= (ctrl.kind == K_CMP) && (MY_IDX < cnt) && (entry_q == ctrl.value);
		rd_q  <= ((ctrl.kind == K_RD) && (MY_IDX == pos)) ? entry_q : '0;
	end

	assign data    = entry_q;
	assign hit     = hit_q;
	assign rd_data = rd_q;

endmodule

`default_nettype wire

### design/positional_list_engine.sv
`default_nettype none

// channel   | direction | handshake              | words
// ----------+-----------+------------------------+-------------------------------------
// command   | in        | start high, busy low   | operation, value, position
// result    | out       | done strobe, one cycle | status, found, read_value, item_count
//
// each command passes through an execute cycle in the cell chain, then the result cycle
// a new command can be taken in the result cycle
// the cells shift, compare and select in the execute cycle; the result ors their outputs
// arst_n clears the fsm and the entry count; entry contents are don't care until written
// the receiver cannot stall: done stands high for exactly one cycle per command

module positional_list_engine #(
	parameter int unsigned CAPACITY = ple_pkg::DEF_CAPACITY,
	parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [2:0]                        operation,
	input  wire logic signed [ple_pkg::DATA_W-1:0] value,
	input  wire logic [CNT_W-1:0]                  position,
	output logic                                   done,
	output logic [1:0]                             status,
	output logic                                   found,
	output logic signed [ple_pkg::DATA_W-1:0]      read_value,
	output logic [CNT_W-1:0]                       item_count
);
	import ple_pkg::*;

	localparam logic [CNT_W-1:0] CAP_L = CNT_W'(CAPACITY);

	// one-hot control fsm
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;

	logic accept;

	// command word captured at accept
	op_t               op_s1;
	logic [DATA_W-1:0] value_s1;
	logic [CNT_W-1:0]  pos_s1;

	// list length, the only control state of the list
	logic [CNT_W-1:0] count_q;

	status_t status_s2;

	// execute-cycle decode
	status_t          st_nxt;
	logic [CNT_W-1:0] cnt_nxt;
	logic [CNT_W-1:0] ins_pos;
	logic [CNT_W-1:0] rem_pos;
	logic [CNT_W-1:0] cell_pos;
	kind_t            kind_nxt;
	cell_ctrl_t       ctrl;

	// chain wiring
	logic [DATA_W-1:0]   cell_data [CAPACITY];
	logic [DATA_W-1:0]   cell_rd   [CAPACITY];
	logic [CAPACITY-1:0] cell_hit;
	logic [CAPACITY-1:0] rd_col    [DATA_W];

	assign busy   = (state_q == S_EXEC);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  state_q <= accept ? S_EXEC : S_IDLE;
				S_EXEC:  state_q <= S_DONE;
				S_DONE:  state_q <= accept ? S_EXEC : S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op_t'(operation);
			value_s1 <= value;
			pos_s1   <= position;
		end
	end

	// target positions: fixed ends for the front and back operations, the given position otherwise
	always_comb begin
		case (op_s1)
			OP_INS_FRONT: ins_pos = '0;
			OP_INS_BACK:  ins_pos = count_q;
			default:      ins_pos = pos_s1;
		endcase
		case (op_s1)
			OP_REM_FRONT: rem_pos = '0;
			OP_REM_BACK:  rem_pos = count_q - CNT_W'(1);
			default:      rem_pos = pos_s1;
		endcase
	end

	// status and cell action; a failing command leaves the list alone
	always_comb begin
		st_nxt   = ST_OK;
		cnt_nxt  = count_q;
		kind_nxt = K_NONE;
		cell_pos = pos_s1;
		case (op_s1)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
				cell_pos = ins_pos;
				if (ins_pos > count_q) begin
					st_nxt = ST_RANGE;
				end else if (count_q >= CAP_L) begin
					st_nxt = ST_FULL;
				end else begin
					kind_nxt = K_INS;
					cnt_nxt  = count_q + CNT_W'(1);
				end
			end
			OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
				cell_pos = rem_pos;
				if (count_q == '0) begin
					st_nxt = ST_EMPTY;
				end else if (rem_pos >= count_q) begin
					st_nxt = ST_RANGE;
				end else begin
					kind_nxt = K_REM;
					cnt_nxt  = count_q - CNT_W'(1);
				end
			end
			OP_CONTAINS: begin
				kind_nxt = K_CMP;
			end
			OP_READ: begin
				if (count_q == '0) begin
					st_nxt = ST_EMPTY;
				end else if (pos_s1 >= count_q) begin
					st_nxt = ST_RANGE;
				end else begin
					kind_nxt = K_RD;
				end
			end
			default: begin
			end
		endcase
	end

	assign ctrl.kind  = (state_q == S_EXEC) ? kind_nxt : K_NONE;
	assign ctrl.value = value_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == S_EXEC) begin
			count_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			status_s2 <= st_nxt;
		end
	end

	// row of cells, index 0 is the front of the list
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = value_s1;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		ple_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.pos        (cell_pos),
			.cnt        (count_q),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i]),
			.hit        (cell_hit[i]),
			.rd_data    (cell_rd[i])
		);
	end

	// only the addressed cell drives nonzero read data, so an or per bit selects it
	always_comb begin
		for (int b = 0; b < DATA_W; b++) begin
			for (int i = 0; i < CAPACITY; i++) begin
				rd_col[b][i] = cell_rd[i][b];
			end
		end
		for (int b = 0; b < DATA_W; b++) begin
			read_value[b] = |rd_col[b];
		end
	end

	assign done       = (state_q == S_DONE);
	assign status     = status_s2;
	assign found      = done && (|cell_hit);
	assign item_count = count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_L)
		else $error("list length above capacity");

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_EXEC))
		else $error("result word without an execute cycle");

	a_count_moves_by_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (count_q == $past(count_q))
			|| (count_q == $past(count_q) + CNT_W'(1))
			|| (count_q == $past(count_q) - CNT_W'(1)))
		else $error("list length moved by more than one");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		found |-> (status == ST_OK))
		else $error("found flag with a failing status");
`endif

endmodule

`default_nettype wire

### tb/positional_list_engine_test.sv
module positional_list_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ple_pkg::*;

	localparam int unsigned CAP         = DEF_CAPACITY;
	localparam int unsigned POS_W       = $clog2(CAP + 1);
	localparam int          RAND_WORDS  = 1000;
	localparam int          CYCLE_LIMIT = 400000;

	// one result word as the block reports it
	typedef struct packed {
		status_t                 st;
		logic                    hit;
		logic signed [DATA_W-1:0] rd;
		logic [POS_W-1:0]        cnt;
	} list_reply_t;

	// one row of the directed table; pinned rows carry a typed-in answer
	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] v;
		logic [POS_W-1:0]         p;
		logic [7:0]               reps;
		logic                     pinned;
		list_reply_t              want;
	} plan_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [2:0]                operation;
	logic signed [DATA_W-1:0]  value;
	logic [POS_W-1:0]          position;
	logic                      done;
	logic [1:0]                status;
	logic                      found;
	logic signed [DATA_W-1:0]  read_value;
	logic [POS_W-1:0]          item_count;

	// shadow copy of the list, front at index 0
	logic signed [DATA_W-1:0] held_values[$];
	// answers waiting for their result word, oldest first
	list_reply_t              pending[$];
	plan_row_t                plan[$];

	// typed-in answer that goes with the word now on the command ports
	logic                     pin_now;
	list_reply_t              pin_want;

	int                       fail_cnt = 0;
	int                       cycle_cnt = 0;

	positional_list_engine #(
		.CAPACITY(CAP)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.value      (value),
		.position   (position),
		.done       (done),
		.status     (status),
		.found      (found),
		.read_value (read_value),
		.item_count (item_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// list behavior: applies one command to the shadow list and returns the answer
	function automatic list_reply_t apply_op(input op_t op, input logic signed [DATA_W-1:0] v,
			input logic [POS_W-1:0] p);
		list_reply_t r;
		int          n;
		int          at;
		n = held_values.size();
		r.st = ST_OK;
		r.hit = 1'b0;
		r.rd = '0;
		case (op)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
				at = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_BACK) ? n : int'(p);
				// range check wins over the full check
				if (at > n)
					r.st = ST_RANGE;
				else if (n >= CAP)
					r.st = ST_FULL;
				else
					held_values.insert(at, v);
			end
			OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
				at = (op == OP_REM_FRONT) ? 0 : (op == OP_REM_BACK) ? n - 1 : int'(p);
				if (n == 0)
					r.st = ST_EMPTY;
				else if (at >= n)
					r.st = ST_RANGE;
				else
					held_values.delete(at);
			end
			OP_CONTAINS: begin
				foreach (held_values[i])
					if (held_values[i] == v)
						r.hit = 1'b1;
			end
			default: begin
				if (n == 0)
					r.st = ST_EMPTY;
				else if (int'(p) >= n)
					r.st = ST_RANGE;
				else
					r.rd = held_values[p];
			end
		endcase
		r.cnt = POS_W'(held_values.size());
		return r;
	endfunction

	// result words are checked first, then an accepted command queues its answer
	always @(posedge clk) begin
		list_reply_t want;
		if (arst_n && done === 1'b1) begin
			if (pending.size() == 0) begin
				$error("result word with no command outstanding");
				fail_cnt++;
			end else begin
				want = pending.pop_front();
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					fail_cnt++;
				end
				if (found !== want.hit) begin
					$error("found: expected %0d, got %0d", want.hit, found);
					fail_cnt++;
				end
				if (read_value !== want.rd) begin
					$error("read_value: expected %0d, got %0d", want.rd, read_value);
					fail_cnt++;
				end
				if (item_count !== want.cnt) begin
					$error("item_count: expected %0d, got %0d", want.cnt, item_count);
					fail_cnt++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			// the shadow list moves even when the answer is typed in
			want = apply_op(op_t'(operation), value, position);
			if (pin_now)
				want = pin_want;
			pending.push_back(want);
		end
	end

	always @(posedge clk)
		cycle_cnt <= cycle_cnt + 1;

	// watchdog
	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("positional_list_engine_test failed");
		$finish;
	end

	task automatic add_row(input op_t op, input logic signed [DATA_W-1:0] v, input int p,
			input int reps, input int pin, input status_t st, input int hit,
			input logic signed [DATA_W-1:0] rd, input int cnt);
		plan_row_t row;
		row.op = op;
		row.v = v;
		row.p = POS_W'(p);
		row.reps = 8'(reps);
		row.pinned = (pin != 0);
		row.want.st = st;
		row.want.hit = (hit != 0);
		row.want.rd = rd;
		row.want.cnt = POS_W'(cnt);
		plan.push_back(row);
	endtask

	// idle gap before a word: start is held low through the gap
	task automatic pause(input int gap);
		repeat (gap) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	// puts one word on the command ports (called at a falling edge) and waits until it is taken
	task automatic drive(input op_t op, input logic signed [DATA_W-1:0] v,
			input logic [POS_W-1:0] p, input logic pin, input list_reply_t want);
		operation = op;
		value = v;
		position = p;
		pin_now = pin;
		pin_want = want;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	// sender holds off until every answer has come back
	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (pending.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		list_reply_t              none;
		op_t                      op;
		logic signed [DATA_W-1:0] v;
		logic [POS_W-1:0]         p;
		int                       n;
		int                       r;
		logic                     grow;
		logic                     calm;

		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_INS_FRONT;
		value = '0;
		position = '0;
		pin_now = 1'b0;
		pin_want = '0;
		none = '0;
		grow = 1'b1;
		calm = 1'b0;

		// accesses on the empty list after reset: reads, removes, contains and out-of-range inserts
		add_row(OP_READ,      0, 0,   1, 1, ST_EMPTY, 0, 0, 0);
		add_row(OP_REM_FRONT, 0, 0,   1, 1, ST_EMPTY, 0, 0, 0);
		add_row(OP_REM_BACK,  0, 0,   1, 1, ST_EMPTY, 0, 0, 0);
		add_row(OP_REM_AT,    0, 0,   1, 1, ST_EMPTY, 0, 0, 0);
		add_row(OP_CONTAINS,  0, 0,   1, 1, ST_OK,    0, 0, 0);
		add_row(OP_INS_AT,    7, 1,   1, 1, ST_RANGE, 0, 0, 0);
		add_row(OP_INS_AT,    7, 127, 1, 1, ST_RANGE, 0, 0, 0);
		// extreme values at the front, back and middle
		add_row(OP_INS_FRONT, 32'sh7fffffff, 0, 1, 1, ST_OK, 0, 0, 1);
		add_row(OP_INS_BACK,  32'sh80000000, 0, 1, 1, ST_OK, 0, 0, 2);
		add_row(OP_INS_AT,    -1,            1, 1, 1, ST_OK, 0, 0, 3);
		add_row(OP_INS_AT,    0,             3, 1, 1, ST_OK, 0, 0, 4);
		add_row(OP_READ,      0, 0,   1, 1, ST_OK,    0, 32'sh7fffffff, 4);
		add_row(OP_READ,      0, 2,   1, 0, ST_OK,    0, 0, 0);
		add_row(OP_READ,      0, 4,   1, 1, ST_RANGE, 0, 0, 4);
		add_row(OP_READ,      0, 127, 1, 1, ST_RANGE, 0, 0, 4);
		add_row(OP_CONTAINS,  32'sh80000000, 0, 1, 0, ST_OK, 0, 0, 0);
		add_row(OP_CONTAINS,  12345,         0, 1, 0, ST_OK, 0, 0, 0);
		add_row(OP_REM_AT,    0, 4,   1, 1, ST_RANGE, 0, 0, 4);
		add_row(OP_REM_AT,    0, 1,   1, 0, ST_OK,    0, 0, 0);
		add_row(OP_REM_FRONT, 0, 0,   1, 0, ST_OK,    0, 0, 0);
		// fill to capacity, then push against the full list
		add_row(OP_INS_BACK,  32'sh5a5a5a5a, 0, CAP - 2, 0, ST_OK, 0, 0, 0);
		add_row(OP_INS_FRONT, 1, 0,   1, 1, ST_FULL,  0, 0, CAP);
		add_row(OP_INS_AT,    1, CAP, 1, 1, ST_FULL,  0, 0, CAP);
		add_row(OP_INS_AT,    1, CAP + 1, 1, 1, ST_RANGE, 0, 0, CAP);
		add_row(OP_REM_AT,    0, CAP - 1, 1, 0, ST_OK, 0, 0, 0);
		add_row(OP_CONTAINS,  0, 0,   1, 0, ST_OK,    0, 0, 0);
		// drain from the back down to empty
		add_row(OP_REM_BACK,  0, 0,   CAP - 1, 0, ST_OK, 0, 0, 0);
		add_row(OP_REM_BACK,  0, 0,   1, 1, ST_EMPTY, 0, 0, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (plan[i]) begin
			repeat (int'(plan[i].reps)) begin
				pause($urandom_range(0, 15));
				@(negedge clk);
				drive(plan[i].op, plan[i].v, plan[i].p, plan[i].pinned,
					plan[i].pinned ? plan[i].want : none);
			end
		end
		wait_drained();

		// random words, drifting between filling and draining the list
		for (int k = 0; k < RAND_WORDS; k++) begin
			// back-to-back stretches now and then
			if (k % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (k % 250 == 249)
				wait_drained();
			pause(calm ? 0 : $urandom_range(0, 15));
			@(negedge clk);
			n = held_values.size();
			// linger at full and empty for a while before turning around
			if (n == CAP && $urandom_range(0, 7) == 0)
				grow = 1'b0;
			if (n == 0 && $urandom_range(0, 7) == 0)
				grow = 1'b1;
			r = $urandom_range(0, 99);
			if (r < (grow ? 55 : 25))
				op = op_t'($urandom_range(0, 2));
			else if (r < 80)
				op = op_t'($urandom_range(3, 5));
			else if (r < 90)
				op = OP_CONTAINS;
			else
				op = OP_READ;
			case ($urandom_range(0, 9))
				0: v = 32'sh7fffffff;
				1: v = 32'sh80000000;
				2, 3, 4: v = $urandom_range(0, 15);
				5, 6: v = (n > 0) ? held_values[$urandom_range(0, n - 1)] : $urandom();
				default: v = $urandom();
			endcase
			// mostly legal positions, sometimes anything the port can carry
			if ($urandom_range(0, 4) == 0)
				p = POS_W'($urandom_range(0, (1 << POS_W) - 1));
			else
				p = POS_W'($urandom_range(0, n));
			drive(op, v, p, 1'b0, none);
		end

		@(negedge clk);
		start = 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_cnt == 0)
			$display("positional_list_engine_test passed");
		else
			$display("positional_list_engine_test failed");
		$finish;
	end

endmodule
